FILE: rtl/lap_pkg.sv
`timescale 1ns / 1ps
package lap_pkg;

	// Line store depth, i.e. the widest frame the block can filter
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	localparam int ROW_W  = 16;
	localparam int FW_W   = 11;
	localparam int FH_W   = 16;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int SUM_W  = CH_W + 3;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	localparam logic LAP_WRAP    = 1'b0;
	localparam logic LAP_ABS_SAT = 1'b1;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_EDGE_MODE    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic             emit;
		logic             filter;
		logic             last;
		logic             wr_newer;
		logic             wr_older;
		logic             fwd_c;
		logic             fwd_r;
		logic             fwd_u;
		logic [COL_W-1:0] addr;
	} s1_ctl_t;

endpackage

FILE: rtl/laplacian_edge_detect_rgb_core.sv
`timescale 1ns / 1ps
// An accepted transaction is registered in stage 1; its result loads into the result
// register when stage 1 advances. Throughput: one transaction per cycle unless a held
// result stalls the input; each line store is read once and written once per cycle,
// and the filter sits between the read registers and the result register.
// Reset (arst_n low, async): row/column/drain counters, pipeline and result valid clear;
// registers return to 640 x 480, truncate mode. Line stores are not cleared.
module laplacian_edge_detect_rgb_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lap_pkg::ADDR_W-1:0]  paddr,
	input  logic [lap_pkg::DATA_W-1:0]  pwdata,
	output logic [lap_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [lap_pkg::CH_W-1:0]    red_in,
	input  logic [lap_pkg::CH_W-1:0]    green_in,
	input  logic [lap_pkg::CH_W-1:0]    blue_in,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lap_pkg::CH_W-1:0]    red_out,
	output logic [lap_pkg::CH_W-1:0]    green_out,
	output logic [lap_pkg::CH_W-1:0]    blue_out,
	output logic                        frame_end
);
	import lap_pkg::*;

	// compare width that holds both the width register and MAX_WIDTH
	localparam int WCMP_W = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic            edge_mode_q;
	reg_idx_t        reg_idx;
	logic            cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
			edge_mode_q    <= LAP_WRAP;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				REG_EDGE_MODE:    edge_mode_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			REG_EDGE_MODE:    prdata = DATA_W'(edge_mode_q);
			default:          prdata = '0;
		endcase
	end

	// Effective frame size: width 0 acts as 1 and is capped at the line store
	// depth, height 0 acts as 1. Both are kept as "last index" values.
	logic [WCMP_W-1:0] fw_ext;
	logic [WCMP_W-1:0] w_eff;
	logic [COL_W-1:0]  wm1;
	logic [ROW_W-1:0]  hm1;

	always_comb begin
		fw_ext = WCMP_W'(frame_width_q);
		if (fw_ext == '0) begin
			w_eff = WCMP_W'(1);
		end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WCMP_W'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		wm1 = COL_W'(w_eff - WCMP_W'(1));
		hm1 = (frame_height_q == '0) ? '0 : ROW_W'(frame_height_q - FH_W'(1));
	end

	// ---------------------------------------------------------------
	// Raster position state
	// ---------------------------------------------------------------
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] drain_idx_q;
	logic             drain_pending_q;

	logic col_last;
	logic row_last;
	logic drain_last;

	assign col_last   = (col_q >= wm1);
	assign row_last   = (row_q >= hm1);
	assign drain_last = (drain_idx_q >= wm1);

	// ---------------------------------------------------------------
	// Handshake
	// ---------------------------------------------------------------
	logic out_valid_q;
	logic valid_s1;
	logic out_free;
	logic accept;
	logic adv;
	logic is_flush;

	assign out_free = !out_valid_q || !out_stall;
	// stage 1 only waits when the result register is full and held
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;
	assign adv      = valid_s1 && out_free;
	assign is_flush = (mode == MODE_FLUSH);

	// ---------------------------------------------------------------
	// Line stores. The newer row store is kept twice so the centre and
	// the right-hand neighbour come out in the same cycle.
	// ---------------------------------------------------------------
	s1_ctl_t          ctl_a;
	s1_ctl_t          ctl_s1;
	rgb_t             pix_s1;
	rgb_t             fwd_newer_s1;
	rgb_t             fwd_older_s1;
	rgb_t             centre_rd;
	rgb_t             right_rd;
	rgb_t             up_rd;
	rgb_t             centre;
	rgb_t             right_px;
	rgb_t             up_px;
	rgb_t             left_q;
	rgb_t             lap_px;
	rgb_t             result;
	logic [COL_W-1:0] rd_right;
	logic             newer_we;
	logic             older_we;

	assign rd_right = col_q + COL_W'(1);

	lap_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_c (
		.clk   (clk),
		.we    (newer_we),
		.waddr (ctl_s1.addr),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (ctl_a.addr),
		.rdata (centre_rd)
	);

	lap_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_r (
		.clk   (clk),
		.we    (newer_we),
		.waddr (ctl_s1.addr),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (rd_right),
		.rdata (right_rd)
	);

	lap_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
		.clk   (clk),
		.we    (older_we),
		.waddr (ctl_s1.addr),
		.wdata (centre),
		.re    (accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	// ---------------------------------------------------------------
	// Accept side: decide what the transaction does, issue the reads.
	// A flush reads the newer row at the drain index; a pixel reads its
	// centre, right neighbour and the pixel above.
	// ---------------------------------------------------------------
	always_comb begin
		ctl_a.emit     = is_flush ? drain_pending_q : (!drain_pending_q && row_q != '0);
		// flushes, the second row, the first column and the last column are copied through
		ctl_a.filter   = !is_flush && (row_q != ROW_W'(1)) && (col_q != '0) && !col_last;
		ctl_a.last     = is_flush && drain_last;
		ctl_a.wr_newer = !is_flush && !drain_pending_q;
		ctl_a.wr_older = !is_flush && !drain_pending_q && (row_q != '0);
		ctl_a.addr     = is_flush ? drain_idx_q : col_q;
		// stage 1 writes this edge; the RAM read would miss it, so bypass
		ctl_a.fwd_c    = newer_we && (ctl_s1.addr == ctl_a.addr);
		ctl_a.fwd_r    = newer_we && (ctl_s1.addr == rd_right);
		ctl_a.fwd_u    = older_we && (ctl_s1.addr == col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q           <= '0;
			col_q           <= '0;
			drain_idx_q     <= '0;
			drain_pending_q <= 1'b0;
		end else if (accept) begin
			if (is_flush) begin
				if (drain_pending_q) begin
					if (drain_last) begin
						drain_pending_q <= 1'b0;
						drain_idx_q     <= '0;
						row_q           <= '0;
						col_q           <= '0;
					end else begin
						drain_idx_q <= drain_idx_q + COL_W'(1);
					end
				end
			end else if (!drain_pending_q) begin
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						// last row stays in the newer store until flushed out
						drain_pending_q <= 1'b1;
						drain_idx_q     <= '0;
						row_q           <= '0;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: filter and line store writeback
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1       <= ctl_a;
			pix_s1       <= '{red: red_in, green: green_in, blue: blue_in};
			fwd_newer_s1 <= pix_s1;
			fwd_older_s1 <= centre;
		end
	end

	always_comb begin
		centre   = ctl_s1.fwd_c ? fwd_newer_s1 : centre_rd;
		right_px = ctl_s1.fwd_r ? fwd_newer_s1 : right_rd;
		up_px    = ctl_s1.fwd_u ? fwd_older_s1 : up_rd;
		newer_we = adv && ctl_s1.wr_newer;
		older_we = adv && ctl_s1.wr_older;
	end

	// The left neighbour is the previous column's centre of the same row,
	// which is exactly what the last older-store write carried.
	always_ff @(posedge clk) begin
		if (older_we) begin
			left_q <= centre;
		end
	end

	lap_filter u_filter (
		.pix_c     (centre),
		.pix_u     (up_px),
		.pix_d     (pix_s1),
		.pix_l     (left_q),
		.pix_r     (right_px),
		.edge_mode (edge_mode_q),
		.lap       (lap_px)
	);

	assign result = ctl_s1.filter ? lap_px : centre;

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	rgb_t out_pix_q;
	logic frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s1.emit) begin
			out_pix_q   <= result;
			frame_end_q <= ctl_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_pix_q.red;
	assign green_out = out_pix_q.green;
	assign blue_out  = out_pix_q.blue;
	assign frame_end = frame_end_q;

endmodule

FILE: rtl/lap_ram.sv
`timescale 1ns / 1ps
module lap_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read at the written address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/lap_filter.sv
`timescale 1ns / 1ps
module lap_filter (
	input  lap_pkg::rgb_t pix_c,
	input  lap_pkg::rgb_t pix_u,
	input  lap_pkg::rgb_t pix_d,
	input  lap_pkg::rgb_t pix_l,
	input  lap_pkg::rgb_t pix_r,
	input  logic          edge_mode,
	output lap_pkg::rgb_t lap
);
	import lap_pkg::*;

	function automatic logic [CH_W-1:0] chan_lap(
		input logic [CH_W-1:0] c,
		input logic [CH_W-1:0] u,
		input logic [CH_W-1:0] d,
		input logic [CH_W-1:0] l,
		input logic [CH_W-1:0] r,
		input logic            md
	);
		logic signed [SUM_W-1:0] s;
		logic        [SUM_W-1:0] a;
		logic        [CH_W-1:0]  res;
		s = signed'({1'b0, c, 2'b00}) - signed'({3'b000, u}) - signed'({3'b000, d})
			- signed'({3'b000, l}) - signed'({3'b000, r});
		a = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
		if (md == LAP_ABS_SAT) begin
			res = (|a[SUM_W-1:CH_W]) ? '1 : a[CH_W-1:0];
		end else begin
			res = s[CH_W-1:0];
		end
		return res;
	endfunction

	always_comb begin
		lap.red   = chan_lap(pix_c.red, pix_u.red, pix_d.red, pix_l.red, pix_r.red,
			edge_mode);
		lap.green = chan_lap(pix_c.green, pix_u.green, pix_d.green, pix_l.green,
			pix_r.green, edge_mode);
		lap.blue  = chan_lap(pix_c.blue, pix_u.blue, pix_d.blue, pix_l.blue, pix_r.blue,
			edge_mode);
	end

endmodule

FILE: rtl/lap_checker.sv
`timescale 1ns / 1ps
module lap_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [lap_pkg::CH_W-1:0] red_out,
	input logic [lap_pkg::CH_W-1:0] green_out,
	input logic [lap_pkg::CH_W-1:0] blue_out,
	input logic                     frame_end
);
	import lap_pkg::*;

	// input side is only held back by a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("in_stall high while result side is not stalled");

	// a new result follows the accepted transaction behind it, through stage 1 and the result register
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a transaction two cycles before");

	// after the last pixel of a frame the next item is a first-row pixel or
	// an ignored flush, neither of which gives a result
	a_frame_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end && !out_stall |=> !out_valid)
		else $error("result directly behind frame end");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(frame_end))
		else $error("stalled result changed");

endmodule

bind laplacian_edge_detect_rgb_core lap_checker u_lap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red_out   (red_out),
	.green_out (green_out),
	.blue_out  (blue_out),
	.frame_end (frame_end)
);
